[hdl/btl_pkg.sv]
// types and constants for the bitmap text layout unit
// no dependencies; every other file refers to it by scoped names
package btl_pkg;

  localparam int CODE_W  = 8;
  localparam int POS_W   = 16;
  localparam int GSIZE_W = 6;
  localparam int SCALE_W = 4;
  localparam int SPACE_W = 8;
  localparam int BOX_W   = 10;
  localparam int TLEN_W  = 12;
  localparam int TEXU_W  = 10;
  localparam int TEXV_W  = 7;
  localparam int ADV_W   = 12;
  localparam int PROD_W  = 25;
  localparam int NUM_W   = 26;
  localparam int USED_W  = 18;
  localparam int IDX_W   = 7;
  localparam int IDX_N   = 128;
  localparam int ROW_W   = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CODE_W-1:0] NEWLINE     = 8'h0A;
  localparam logic [CODE_W-1:0] FIRST_GLYPH = 8'h21;
  localparam logic [CODE_W-1:0] LAST_GLYPH  = 8'h7F;

  localparam logic [GSIZE_W-1:0] GSIZE_RST = 6'd8;
  localparam logic [SCALE_W-1:0] SCALE_RST = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_GLYPH_SIZE,
    CFG_GLYPH_SCALE,
    CFG_LETTER_SPACE,
    CFG_BOX_WIDTH,
    CFG_CENTER_ENABLE,
    CFG_TEXT_LENGTH
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_MUL,
    ST_RELOAD,
    ST_STEP
  } state_e;

  typedef struct packed {
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic [GSIZE_W-1:0]      glyph_size;
    logic [SCALE_W-1:0]      glyph_scale;
    logic signed [SPACE_W-1:0] letter_space;
    logic [BOX_W-1:0]        box_width;
    logic                    center_enable;
    logic [TLEN_W-1:0]       text_length;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic              first_char;
  } in_item_t;

  typedef struct packed {
    logic                    draw_glyph;
    logic signed [POS_W-1:0] screen_x;
    logic signed [POS_W-1:0] screen_y;
    logic [TEXU_W-1:0]       tex_u;
    logic [TEXV_W-1:0]       tex_v;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic mul;
    logic reload;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

[hdl/btl_intf.sv]
// valid/ready channel interfaces of the bitmap text layout unit
// depends on btl_pkg
interface btl_in_if;
  logic              valid;
  logic              ready;
  btl_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface btl_out_if;
  logic               valid;
  logic               ready;
  btl_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface btl_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [btl_pkg::CFG_IDX_W-1:0]      index;
  logic [btl_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/btl_ctrl.sv]
// sequencing state machine of the bitmap text layout unit
// depends on btl_pkg
module btl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_first_i,
  output logic               in_ready_o,
  input  btl_pkg::status_t   status_i,
  output btl_pkg::cmd_t      cmd_o
);

  btl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      btl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_first_i ? btl_pkg::ST_PRE : btl_pkg::ST_STEP;
        end
      end
      btl_pkg::ST_PRE:    state_d = btl_pkg::ST_MUL;
      btl_pkg::ST_MUL:    state_d = btl_pkg::ST_RELOAD;
      btl_pkg::ST_RELOAD: state_d = btl_pkg::ST_STEP;
      btl_pkg::ST_STEP: begin
        if (status_i.out_free) begin
          state_d = btl_pkg::ST_IDLE;
        end
      end
      default: state_d = btl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      btl_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.latch  = in_valid_i;
      end
      btl_pkg::ST_PRE:    ;
      btl_pkg::ST_MUL:    cmd_o.mul = 1'b1;
      btl_pkg::ST_RELOAD: cmd_o.reload = 1'b1;
      btl_pkg::ST_STEP:   cmd_o.step = status_i.out_free;
      default: ;
    endcase
  end

endmodule

[hdl/btl_datapath.sv]
// pen state, advance, centering and texel arithmetic with the result register
// depends on btl_pkg
module btl_datapath #(
  parameter int GLYPHS_PER_ROW = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  btl_pkg::cfg_t       cfg_i,
  input  btl_pkg::cmd_t       cmd_i,
  input  btl_pkg::in_item_t   in_item_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output btl_pkg::out_item_t  out_item_o,
  output btl_pkg::status_t    status_o
);

  localparam int ColW = (GLYPHS_PER_ROW > 1) ? $clog2(GLYPHS_PER_ROW) : 1;
  localparam int UProdW = ColW + btl_pkg::GSIZE_W;
  localparam int VProdW = btl_pkg::ROW_W + btl_pkg::GSIZE_W;

  logic [btl_pkg::CODE_W-1:0]        code_q;
  logic signed [btl_pkg::ADV_W-1:0]  adv, adv_q;
  logic signed [btl_pkg::PROD_W-1:0] prod_q;
  logic signed [btl_pkg::NUM_W-1:0]  num, half;
  logic signed [btl_pkg::POS_W-1:0]  reload_x, adv16;
  logic signed [btl_pkg::POS_W-1:0]  pen_x_q, pen_y_q, line_start_q, line_used_q;
  logic signed [btl_pkg::POS_W-1:0]  px, py, lu;
  logic signed [btl_pkg::USED_W-1:0] used_sum;
  logic                              is_nl, brk, drawable;
  logic [btl_pkg::IDX_W-1:0]         idx;
  logic [ColW-1:0]                   col_tab [btl_pkg::IDX_N];
  logic [btl_pkg::ROW_W-1:0]         row_tab [btl_pkg::IDX_N];
  logic [UProdW-1:0]                 u_prod;
  logic [VProdW-1:0]                 v_prod;
  logic                              out_valid_q;
  btl_pkg::out_item_t                out_q, out_d;

  // advance per character, also the line pitch
  assign adv = $signed({2'b00, 10'(cfg_i.glyph_size * cfg_i.glyph_scale)})
             + $signed({{4{cfg_i.letter_space[7]}}, cfg_i.letter_space});
  assign adv16 = btl_pkg::POS_W'(adv);

  always_ff @(posedge clk_i) begin
    adv_q <= adv;
    if (cmd_i.mul) begin
      prod_q <= $signed({1'b0, cfg_i.text_length}) * adv_q;
    end
    if (cmd_i.latch) begin
      code_q <= in_item_i.char_code;
    end
  end

  // centering offset, halved toward zero
  assign num  = $signed({16'd0, cfg_i.box_width}) - btl_pkg::NUM_W'(prod_q);
  assign half = (num + $signed({25'd0, num[btl_pkg::NUM_W-1]})) >>> 1;
  assign reload_x = cfg_i.center_enable ? cfg_i.origin_x + btl_pkg::POS_W'(half)
                                        : cfg_i.origin_x;

  // line break test
  assign used_sum = btl_pkg::USED_W'(line_used_q) + btl_pkg::USED_W'(adv);
  assign is_nl = (code_q == btl_pkg::NEWLINE);
  assign brk = ((cfg_i.box_width != '0) &&
                (used_sum > $signed({8'd0, cfg_i.box_width}))) || is_nl;
  assign px = brk ? line_start_q : pen_x_q;
  assign py = brk ? pen_y_q + adv16 : pen_y_q;
  assign lu = brk ? '0 : line_used_q;
  assign drawable = (code_q >= btl_pkg::FIRST_GLYPH) && (code_q <= btl_pkg::LAST_GLYPH);

  // atlas cell row and column tables
  for (genvar g = 0; g < btl_pkg::IDX_N; g++) begin : g_tab
    assign row_tab[g] = btl_pkg::ROW_W'(g / GLYPHS_PER_ROW);
    assign col_tab[g] = ColW'(g % GLYPHS_PER_ROW);
  end

  assign idx    = btl_pkg::IDX_W'(code_q - btl_pkg::FIRST_GLYPH);
  assign u_prod = UProdW'(col_tab[idx]) * UProdW'(cfg_i.glyph_size);
  assign v_prod = VProdW'(row_tab[idx]) * VProdW'(cfg_i.glyph_size);

  always_comb begin
    out_d = '0;
    if (drawable && !is_nl) begin
      out_d.draw_glyph = 1'b1;
      out_d.screen_x   = px;
      out_d.screen_y   = py;
      out_d.tex_u      = btl_pkg::TEXU_W'(u_prod);
      out_d.tex_v      = btl_pkg::TEXV_W'(v_prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q      <= '0;
      pen_y_q      <= '0;
      line_start_q <= '0;
      line_used_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.reload) begin
        pen_x_q      <= reload_x;
        line_start_q <= reload_x;
        pen_y_q      <= cfg_i.origin_y;
        line_used_q  <= '0;
      end else if (cmd_i.step) begin
        pen_y_q <= py;
        if (is_nl) begin
          pen_x_q     <= px;
          line_used_q <= '0;
        end else begin
          pen_x_q     <= px + adv16;
          line_used_q <= lu + adv16;
        end
      end
      if (cmd_i.step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_q <= out_d;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[hdl/bitmap_text_layout_unit.sv]
// top level of the bitmap text layout unit: configuration registers, controller, datapath
// depends on btl_pkg, btl_intf, btl_ctrl and btl_datapath
//
// Places one character of a bitmap-font string per input beat and returns one
// result beat per character: a draw flag, the 16-bit wrapping screen position
// and the atlas texel (u, v) of the glyph cell. An ordinary character is accepted,
// then takes the step that updates the pen and loads the result register. A
// character with first_char set passes through ST_PRE, ST_MUL and ST_RELOAD
// before the step, since the pen reload goes through a registered advance, the
// text_length times advance multiply and the centering add. The result register
// lets the next character be accepted while a finished result still waits; a
// stalled output holds the step until the result register is free.
// Configuration writes are taken every cycle and land in the register file
// here; they are expected only while no character is in flight.
module bitmap_text_layout_unit #(
  parameter int GLYPHS_PER_ROW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  btl_in_if.sink          in_i,
  btl_out_if.source       out_o,
  btl_cfg_if.sink         cfg_i
);

  btl_pkg::cfg_t    cfg_q;
  btl_pkg::cmd_t    cmd;
  btl_pkg::status_t status;
  logic             in_ready;
  logic             out_valid;
  btl_pkg::out_item_t out_item;

  // configuration register file, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
      cfg_q.glyph_size    <= btl_pkg::GSIZE_RST;
      cfg_q.glyph_scale   <= btl_pkg::SCALE_RST;
      cfg_q.letter_space  <= '0;
      cfg_q.box_width     <= '0;
      cfg_q.center_enable <= 1'b1;
      cfg_q.text_length   <= '0;
    end else if (cfg_i.valid) begin
      case (btl_pkg::cfg_idx_e'(cfg_i.index))
        btl_pkg::CFG_ORIGIN_X:      cfg_q.origin_x      <= cfg_i.data;
        btl_pkg::CFG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_i.data;
        btl_pkg::CFG_GLYPH_SIZE:    cfg_q.glyph_size    <= cfg_i.data[btl_pkg::GSIZE_W-1:0];
        btl_pkg::CFG_GLYPH_SCALE:   cfg_q.glyph_scale   <= cfg_i.data[btl_pkg::SCALE_W-1:0];
        btl_pkg::CFG_LETTER_SPACE:  cfg_q.letter_space  <= cfg_i.data[btl_pkg::SPACE_W-1:0];
        btl_pkg::CFG_BOX_WIDTH:     cfg_q.box_width     <= cfg_i.data[btl_pkg::BOX_W-1:0];
        btl_pkg::CFG_CENTER_ENABLE: cfg_q.center_enable <= cfg_i.data[0];
        btl_pkg::CFG_TEXT_LENGTH:   cfg_q.text_length   <= cfg_i.data[btl_pkg::TLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // controller owns the input handshake and sequences the datapath
  btl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_first_i (in_i.data.first_char),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // datapath holds the pen state and the result register
  btl_datapath #(
    .GLYPHS_PER_ROW (GLYPHS_PER_ROW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .in_item_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .status_o    (status)
  );

  assign out_o.valid = out_valid;
  assign out_o.data  = out_item;

endmodule
